[rtl/ssp_pkg.sv]
package ssp_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        V_OK      = 3'd0,
        V_TIMEOUT = 3'd1,
        V_BADLEN  = 3'd2,
        V_WRONGID = 3'd3,
        V_BADSUM  = 3'd4,
        V_TOOLONG = 3'd5
    } t_verdict;

    typedef enum logic [0:0] {
        KIND_DATA    = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        REG_EXPECTED_ID = 2'd0,
        REG_CAPACITY    = 2'd1,
        REG_TIMEOUT     = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    localparam logic [7:0]  RST_EXPECTED_ID = 8'd1;
    localparam logic [7:0]  RST_CAPACITY    = 8'd11;
    localparam logic [15:0] RST_TIMEOUT     = 16'd80;
    localparam logic [7:0]  SYNC_BYTE       = 8'hFF;
    localparam logic [7:0]  MIN_LENGTH      = 8'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [0:0] result_kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [2:0] verdict;
        logic [7:0] status_error;
        logic [7:0] payload_length;
        logic [0:0] last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  expected_id;
        logic [7:0]  payload_capacity;
        logic [15:0] timeout_ticks;
    } t_cfg;

endpackage

[rtl/ssp_regs.sv]
module ssp_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output ssp_pkg::t_cfg      o_cfg
);
    import ssp_pkg::*;

    logic [7:0]  r_expected_id;
    logic [7:0]  r_capacity;
    logic [15:0] r_timeout;
    logic        wr_en;
    t_reg_idx    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= RST_EXPECTED_ID;
            r_capacity    <= RST_CAPACITY;
            r_timeout     <= RST_TIMEOUT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_EXPECTED_ID: r_expected_id <= pwdata[7:0];
                REG_CAPACITY:    r_capacity    <= pwdata[7:0];
                REG_TIMEOUT:     r_timeout     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_EXPECTED_ID: prdata = {24'd0, r_expected_id};
            REG_CAPACITY:    prdata = {24'd0, r_capacity};
            REG_TIMEOUT:     prdata = {16'd0, r_timeout};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg.expected_id      = r_expected_id;
    assign o_cfg.payload_capacity = r_capacity;
    assign o_cfg.timeout_ticks    = r_timeout;

endmodule

[rtl/ssp_parse.sv]
module ssp_parse #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  ssp_pkg::t_in_item  i_item,
    input  ssp_pkg::t_cfg      i_cfg,
    output logic               o_res_valid,
    output ssp_pkg::t_out_item o_res
);
    import ssp_pkg::*;

    localparam logic [8:0] LenMax = 9'(MAX_FRAME_BYTES - 4);

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_HUNT = 7'b0000010,
        PH_ID   = 7'b0000100,
        PH_LEN  = 7'b0001000,
        PH_ERR  = 7'b0010000,
        PH_DATA = 7'b0100000,
        PH_CSUM = 7'b1000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_pos, n_pos;
    logic        r_prev_ff, n_prev_ff;
    logic [7:0]  r_seen_id, n_seen_id;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_err, n_err;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_ticks, n_ticks;

    t_op         op;
    logic [7:0]  b;
    logic [7:0]  sum_add;
    logic [7:0]  plen;
    logic [7:0]  pos_inc;
    logic [15:0] ticks_inc;
    logic        is_ff;

    assign op        = t_op'(i_item.operation);
    assign b         = i_item.rx_byte;
    assign is_ff     = (b == SYNC_BYTE);
    assign sum_add   = r_sum + b;
    assign plen      = r_len - MIN_LENGTH;
    assign pos_inc   = r_pos + 8'd1;
    assign ticks_inc = r_ticks + 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_prev_ff   = r_prev_ff;
        n_seen_id   = r_seen_id;
        n_len       = r_len;
        n_err       = r_err;
        n_sum       = r_sum;
        n_ticks     = r_ticks;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.result_kind = KIND_VERDICT;
        o_res.last        = 1'b1;

        if (op == OP_START) begin
            n_phase   = PH_HUNT;
            n_pos     = '0;
            n_prev_ff = 1'b0;
            n_seen_id = '0;
            n_len     = '0;
            n_err     = '0;
            n_sum     = '0;
            n_ticks   = '0;
        end else if (r_phase != PH_IDLE && op == OP_TICK) begin
            n_ticks = ticks_inc;
            if (ticks_inc >= i_cfg.timeout_ticks) begin
                o_res_valid   = 1'b1;
                o_res.verdict = V_TIMEOUT;
                n_phase       = PH_IDLE;
            end
        end else if (r_phase != PH_IDLE && op == OP_BYTE) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (is_ff && r_prev_ff) begin
                        n_phase   = PH_ID;
                        n_prev_ff = 1'b0;
                    end else begin
                        n_prev_ff = is_ff;
                    end
                end
                PH_ID: begin
                    if (!is_ff) begin
                        n_seen_id = b;
                        n_sum     = b;
                        n_phase   = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len = b;
                    n_sum = sum_add;
                    if (b < MIN_LENGTH || {1'b0, b} > LenMax) begin
                        o_res_valid   = 1'b1;
                        o_res.verdict = V_BADLEN;
                        n_phase       = PH_IDLE;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_ERR: begin
                    n_err   = b;
                    n_sum   = sum_add;
                    n_pos   = '0;
                    n_phase = (r_len > MIN_LENGTH) ? PH_DATA : PH_CSUM;
                end
                PH_DATA: begin
                    n_sum               = sum_add;
                    o_res_valid         = 1'b1;
                    o_res.result_kind   = KIND_DATA;
                    o_res.last          = 1'b0;
                    o_res.payload_byte  = b;
                    o_res.payload_index = r_pos;
                    n_pos               = pos_inc;
                    if (pos_inc >= plen) begin
                        n_phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    o_res_valid = 1'b1;
                    n_phase     = PH_IDLE;
                    priority if (r_seen_id != i_cfg.expected_id) begin
                        o_res.verdict = V_WRONGID;
                    end else if (~r_sum != b) begin
                        o_res.verdict = V_BADSUM;
                    end else if (plen > i_cfg.payload_capacity) begin
                        o_res.verdict        = V_TOOLONG;
                        o_res.status_error   = r_err;
                        o_res.payload_length = plen;
                    end else begin
                        o_res.verdict        = V_OK;
                        o_res.status_error   = r_err;
                        o_res.payload_length = plen;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= '0;
            r_prev_ff <= 1'b0;
            r_seen_id <= '0;
            r_len     <= '0;
            r_err     <= '0;
            r_sum     <= '0;
            r_ticks   <= '0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_prev_ff <= n_prev_ff;
            r_seen_id <= n_seen_id;
            r_len     <= n_len;
            r_err     <= n_err;
            r_sum     <= n_sum;
            r_ticks   <= n_ticks;
        end
    end

endmodule

[rtl/servo_status_packet_parser_core.sv]
// Servo status packet parser.
// Input channel (i_in_valid / o_in_ready, i_in_item): one request per item,
// operation start, received bus byte or timer tick. Output channel
// (o_out_valid / i_out_ready, o_out_item): payload bytes as they arrive and
// one final verdict per reception; drop the payload unless the verdict is ok.
// Configuration: APB port, expected id at 0x0, payload capacity at 0x4,
// timeout ticks at 0x8; write only while no request is in flight.
// Path: a request accepted into the input register goes through the parse logic,
// and its result is registered in the output register that drives o_out_valid.
// Throughput: one request per cycle while the receiver takes results; the
// parser state updates once per request in the single parse stage.
// Stall: with i_out_ready low the output register holds its result, the
// input register holds one more request, and o_in_ready then drops.
// Reset (i_rst_n low, synchronous): parser idle, both registers empty,
// configuration back to id 1, capacity 11, timeout 80 ticks.
module servo_status_packet_parser_core #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ssp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ssp_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ssp_pkg::*;

    t_cfg       cfg;
    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic       advance;
    logic       proc_en;
    logic       res_valid;
    t_out_item  res;

    ssp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ssp_parse #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (proc_en),
        .i_item      (r_in_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign advance    = !r_out_valid || i_out_ready;
    assign proc_en    = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= proc_en && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_en && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while both stages are full");

    a_data_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind == KIND_DATA) |->
        (o_out_item.last == 1'b0 && o_out_item.verdict == V_OK))
        else $error("payload byte carries verdict fields");

    a_verdict_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind == KIND_VERDICT
         && o_out_item.verdict != V_OK && o_out_item.verdict != V_TOOLONG) |->
        (o_out_item.status_error == 8'd0 && o_out_item.payload_length == 8'd0))
        else $error("failed verdict reports servo error or length");

    a_no_output_without_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && advance) |=> !o_out_valid)
        else $error("result produced without a request");

endmodule
